>>> rtl/ssct_pkg.sv
package ssct_pkg;

    // Coordinate lane width; every datapath width below follows from it.
    localparam int COORD_BITS = 16;

    // Fixed widths of the packed center and radius fields.
    localparam int CENTER_W = 48;
    localparam int RADIUS_W = 16;

    // Start offset, relative motion and radius sum.
    localparam int D_W = COORD_BITS + 1;
    localparam int V_W = COORD_BITS + 2;
    localparam int R_W = COORD_BITS + 1;

    // Magnitude width for v.v, v.d, d.d, r*r and c (sum of three products plus sign).
    localparam int M_W    = 2 * COORD_BITS + 4;
    localparam int HALF_W = M_W / 2;
    localparam int P_W    = 2 * M_W;

    // Span used to slice lanes and radius when the lane layout outgrows the field.
    localparam int LANE_SPAN = (3 * COORD_BITS > CENTER_W) ? 3 * COORD_BITS : CENTER_W;
    localparam int RAD_SPAN  = (COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] rad_t;
    typedef logic signed [D_W-1:0]        dif_t;
    typedef logic signed [V_W-1:0]        vel_t;
    typedef logic        [R_W-1:0]        rsum_t;
    typedef logic        [M_W-1:0]        mag_t;
    typedef logic signed [M_W-1:0]        smag_t;
    typedef logic        [HALF_W-1:0]     half_t;
    typedef logic        [P_W-1:0]        prod_t;

    // Final-stage status handed from the root test to the output register.
    typedef struct packed {
        logic valid;
        logic start;
        logic hit;
    } verdict_t;

    // Signed lane k of a packed center; bits above the field read as zero.
    function automatic coord_t lane(input logic [CENTER_W-1:0] field, input logic [1:0] k);
        logic [LANE_SPAN-1:0] ext;
        ext = LANE_SPAN'(field);
        return coord_t'(ext[COORD_BITS * k +: COORD_BITS]);
    endfunction

    // Low COORD_BITS of a radius field; bits above the field read as zero.
    function automatic rad_t radius(input logic [RADIUS_W-1:0] field);
        logic [RAD_SPAN-1:0] ext;
        ext = RAD_SPAN'(field);
        return ext[COORD_BITS-1:0];
    endfunction

endpackage

>>> rtl/ssct_if.sv
interface ssct_query_if;
    logic                          valid;
    logic                          ready;
    logic [ssct_pkg::CENTER_W-1:0] sphere_a_start;
    logic [ssct_pkg::CENTER_W-1:0] sphere_a_end;
    logic [ssct_pkg::RADIUS_W-1:0] radius_a;
    logic [ssct_pkg::CENTER_W-1:0] sphere_b_start;
    logic [ssct_pkg::CENTER_W-1:0] sphere_b_end;
    logic [ssct_pkg::RADIUS_W-1:0] radius_b;

    modport source (
        output valid, sphere_a_start, sphere_a_end, radius_a,
               sphere_b_start, sphere_b_end, radius_b,
        input  ready
    );
    modport sink (
        input  valid, sphere_a_start, sphere_a_end, radius_a,
               sphere_b_start, sphere_b_end, radius_b,
        output ready
    );
endinterface

interface ssct_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );
    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

>>> rtl/ssct_prep.sv
module ssct_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ssct_pkg::CENTER_W-1:0] sphere_a_start,
    input  logic [ssct_pkg::CENTER_W-1:0] sphere_a_end,
    input  logic [ssct_pkg::RADIUS_W-1:0] radius_a,
    input  logic [ssct_pkg::CENTER_W-1:0] sphere_b_start,
    input  logic [ssct_pkg::CENTER_W-1:0] sphere_b_end,
    input  logic [ssct_pkg::RADIUS_W-1:0] radius_b,
    output logic                          out_valid,
    output ssct_pkg::dif_t                d [3],
    output ssct_pkg::vel_t                v [3],
    output ssct_pkg::rsum_t               r
);
    import ssct_pkg::*;

    logic  valid_reg;
    dif_t  d_reg [3];
    dif_t  d_next [3];
    vel_t  v_reg [3];
    vel_t  v_next [3];
    rsum_t r_reg;
    rsum_t r_next;

    // Relative start offset and relative motion per axis.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = D_W'(lane(sphere_b_start, 2'(k))) - D_W'(lane(sphere_a_start, 2'(k)));
            v_next[k] = V_W'(lane(sphere_b_end, 2'(k))) - V_W'(lane(sphere_b_start, 2'(k)))
                      - V_W'(lane(sphere_a_end, 2'(k))) + V_W'(lane(sphere_a_start, 2'(k)));
        end
        r_next = R_W'(radius(radius_a)) + R_W'(radius(radius_b));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign out_valid = valid_reg;
    assign d         = d_reg;
    assign v         = v_reg;
    assign r         = r_reg;

endmodule

>>> rtl/ssct_dot.sv
module ssct_dot (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  ssct_pkg::dif_t   d [3],
    input  ssct_pkg::vel_t   v [3],
    input  ssct_pkg::rsum_t  r,
    output logic             out_valid,
    output ssct_pkg::mag_t   dd,
    output ssct_pkg::mag_t   a,
    output ssct_pkg::smag_t  h,
    output ssct_pkg::mag_t   rr
);
    import ssct_pkg::*;

    // Product stage.
    logic                          p_valid_reg;
    logic signed [2*D_W-1:0]       dd_p_reg [3];
    logic signed [2*V_W-1:0]       vv_p_reg [3];
    logic signed [V_W+D_W-1:0]     vd_p_reg [3];
    logic        [2*R_W-1:0]       rr_p_reg;

    // Sum stage.
    logic  s_valid_reg;
    mag_t  dd_reg;
    mag_t  dd_next;
    mag_t  a_reg;
    mag_t  a_next;
    smag_t h_reg;
    smag_t h_next;
    mag_t  rr_reg;
    mag_t  rr_next;

    always_comb
    begin
        dd_next = M_W'($unsigned(dd_p_reg[0])) + M_W'($unsigned(dd_p_reg[1]))
                + M_W'($unsigned(dd_p_reg[2]));
        a_next  = M_W'($unsigned(vv_p_reg[0])) + M_W'($unsigned(vv_p_reg[1]))
                + M_W'($unsigned(vv_p_reg[2]));
        h_next  = M_W'(vd_p_reg[0]) + M_W'(vd_p_reg[1]) + M_W'(vd_p_reg[2]);
        rr_next = M_W'(rr_p_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= in_valid;
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dd_p_reg[k] <= d[k] * d[k];
                vv_p_reg[k] <= v[k] * v[k];
                vd_p_reg[k] <= v[k] * d[k];
            end
            rr_p_reg <= r * r;
            dd_reg   <= dd_next;
            a_reg    <= a_next;
            h_reg    <= h_next;
            rr_reg   <= rr_next;
        end
    end

    assign out_valid = s_valid_reg;
    assign dd        = dd_reg;
    assign a         = a_reg;
    assign h         = h_reg;
    assign rr        = rr_reg;

endmodule

>>> rtl/ssct_root.sv
module ssct_root (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ssct_pkg::mag_t     dd,
    input  ssct_pkg::mag_t     a,
    input  ssct_pkg::smag_t    h,
    input  ssct_pkg::mag_t     rr,
    output ssct_pkg::verdict_t verdict
);
    import ssct_pkg::*;

    // Classify stage: start contact, c, -h.
    logic c_valid_reg;
    logic c_start_reg;
    logic c_azero_reg;
    logic c_hpos_reg;
    mag_t c_a_reg;
    mag_t c_c_reg;
    mag_t c_hm_reg;

    // Partial product stage.
    logic p_valid_reg;
    logic p_start_reg;
    logic p_azero_reg;
    logic p_hpos_reg;
    logic p_lin_reg;
    mag_t p_hh_hi_reg;
    mag_t p_hh_x_reg;
    mag_t p_hh_lo_reg;
    mag_t p_ac_hh_reg;
    mag_t p_ac_hl_reg;
    mag_t p_ac_lh_reg;
    mag_t p_ac_ll_reg;
    logic lin_next;

    // Accumulate stage.
    logic  s_valid_reg;
    logic  s_start_reg;
    logic  s_azero_reg;
    logic  s_hpos_reg;
    logic  s_lin_reg;
    prod_t s_hh_reg;
    prod_t s_hh_next;
    prod_t s_ac_reg;
    prod_t s_ac_next;

    half_t hm_hi;
    half_t hm_lo;
    half_t a_hi;
    half_t a_lo;
    half_t c_hi;
    half_t c_lo;

    assign hm_hi = c_hm_reg[M_W-1:HALF_W];
    assign hm_lo = c_hm_reg[HALF_W-1:0];
    assign a_hi  = c_a_reg[M_W-1:HALF_W];
    assign a_lo  = c_a_reg[HALF_W-1:0];
    assign c_hi  = c_c_reg[M_W-1:HALF_W];
    assign c_lo  = c_c_reg[HALF_W-1:0];

    // Root inside the step: a + 2h + c <= 0, or the vertex -h/a lies at or before t = 1.
    assign lin_next = ((M_W+1)'(c_a_reg) + (M_W+1)'(c_c_reg) <= {c_hm_reg, 1'b0})
                   || (c_hm_reg <= c_a_reg);

    always_comb
    begin
        s_hh_next = (P_W'(p_hh_hi_reg) << (2 * HALF_W))
                  + (P_W'(p_hh_x_reg) << (HALF_W + 1))
                  + P_W'(p_hh_lo_reg);
        s_ac_next = (P_W'(p_ac_hh_reg) << (2 * HALF_W))
                  + ((P_W'(p_ac_hl_reg) + P_W'(p_ac_lh_reg)) << HALF_W)
                  + P_W'(p_ac_ll_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= in_valid;
            p_valid_reg <= c_valid_reg;
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_start_reg <= (dd <= rr);
            c_azero_reg <= (a == '0);
            c_hpos_reg  <= !h[M_W-1];
            c_a_reg     <= a;
            c_c_reg     <= dd - rr;
            c_hm_reg    <= mag_t'(-h);

            p_start_reg <= c_start_reg;
            p_azero_reg <= c_azero_reg;
            p_hpos_reg  <= c_hpos_reg;
            p_lin_reg   <= lin_next;
            p_hh_hi_reg <= hm_hi * hm_hi;
            p_hh_x_reg  <= hm_hi * hm_lo;
            p_hh_lo_reg <= hm_lo * hm_lo;
            p_ac_hh_reg <= a_hi * c_hi;
            p_ac_hl_reg <= a_hi * c_lo;
            p_ac_lh_reg <= a_lo * c_hi;
            p_ac_ll_reg <= a_lo * c_lo;

            s_start_reg <= p_start_reg;
            s_azero_reg <= p_azero_reg;
            s_hpos_reg  <= p_hpos_reg;
            s_lin_reg   <= p_lin_reg;
            s_hh_reg    <= s_hh_next;
            s_ac_reg    <= s_ac_next;
        end
    end

    // Discriminant h*h >= a*c closes the moving case.
    always_comb
    begin
        verdict.valid = s_valid_reg;
        verdict.start = s_start_reg;
        verdict.hit   = s_start_reg
                     || (!s_azero_reg && !s_hpos_reg && s_lin_reg && (s_hh_reg >= s_ac_reg));
    end

endmodule

>>> rtl/swept_sphere_contact_test.sv
// Swept sphere-sphere contact test, fully pipelined.
// Throughput: one transfer per cycle while the sink takes results; the seven register
// stages (difference, product, sum, classify, partial product, accumulate, output) all
// advance together.
// Reset: rst_n asynchronously clears every valid bit; data registers are not reset.
module swept_sphere_contact_test (
    input  logic          clk,
    input  logic          rst_n,
    ssct_query_if.sink    query,
    ssct_result_if.source result
);
    import ssct_pkg::*;

    // Pipeline enable: the whole pipe advances unless the output register holds a
    // result that the sink has not taken. Holding the pipe keeps every stage
    // in place, so no transfer is dropped or repeated.
    logic     en;
    logic     out_valid_reg;
    logic     out_hit_reg;

    // Stage 1 outputs: relative offset d, relative motion v, radius sum r.
    logic     prep_valid;
    dif_t     d [3];
    vel_t     v [3];
    rsum_t    r;

    // Stage 3 outputs: d.d, v.v, v.d and r*r.
    logic     dot_valid;
    mag_t     dd;
    mag_t     a;
    smag_t    h;
    mag_t     rr;

    // Stage 6 outputs: final decision.
    verdict_t verdict;

    assign en          = !out_valid_reg || result.ready;
    assign query.ready = en;

    ssct_prep u_prep (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (query.valid),
        .sphere_a_start (query.sphere_a_start),
        .sphere_a_end   (query.sphere_a_end),
        .radius_a       (query.radius_a),
        .sphere_b_start (query.sphere_b_start),
        .sphere_b_end   (query.sphere_b_end),
        .radius_b       (query.radius_b),
        .out_valid      (prep_valid),
        .d              (d),
        .v              (v),
        .r              (r)
    );

    // Dot products: one stage of 18x18-class multipliers, one stage of three-way sums.
    ssct_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .d         (d),
        .v         (v),
        .r         (r),
        .out_valid (dot_valid),
        .dd        (dd),
        .a         (a),
        .h         (h),
        .rr        (rr)
    );

    // Root test: classify, split the wide squares into half-width partial
    // products, accumulate them, then compare h*h against a*c.
    ssct_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (dot_valid),
        .dd       (dd),
        .a        (a),
        .h        (h),
        .rr       (rr),
        .verdict  (verdict)
    );

    // Output register: parts the sink from the pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= verdict.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg <= verdict.hit;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.hit   = out_hit_reg;

    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> query.ready)
        else $error("input stalled with an empty output register");

    // A pending result that is not taken holds the whole pipe.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !query.ready)
        else $error("input taken while output is stalled");

    // Overlap at the start always reports contact.
    a_start_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.start) |-> verdict.hit)
        else $error("start overlap without contact");

endmodule
